>>> rtl/recursive_frame_blend_assert.svh
// Assertion macros shared by the recursive frame blend RTL.
`ifndef RECURSIVE_FRAME_BLEND_ASSERT_SVH
`define RECURSIVE_FRAME_BLEND_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFB_ASSERT_NOW(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("recursive_frame_blend: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RFB_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("recursive_frame_blend: assertion failed");

`endif

>>> rtl/rfb_pkg.sv
// Package: shared types, constants and helpers of the recursive frame blend.
package rfb_pkg;

	localparam int LANES  = 4;
	localparam int PIX_W  = 8;
	localparam int GAIN_W = 8;
	localparam int HIST_W = 18;
	localparam int FW_W   = 18;
	localparam int CFG_W  = 18;
	localparam int IDX_W  = 2;

	localparam int MAX_FRAME_WORDS_DEF = 131072;
	localparam int ALPHA_LANE_DEF      = 3;

	// Register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_MODE         = 2'd0;
	localparam logic [IDX_W-1:0] REG_INPUT_GAIN   = 2'd1;
	localparam logic [IDX_W-1:0] REG_HISTORY_GAIN = 2'd2;
	localparam logic [IDX_W-1:0] REG_FRAME_WORDS  = 2'd3;

	// Blend modes
	localparam logic MODE_RGBA = 1'b0;
	localparam logic MODE_YUV  = 1'b1;

	// Register reset values
	localparam logic [GAIN_W-1:0] INPUT_GAIN_RST   = 8'd255;
	localparam logic [GAIN_W-1:0] HISTORY_GAIN_RST = 8'd0;
	localparam logic [FW_W-1:0]   FRAME_WORDS_RST  = 18'd76800;

	// History reset: even lanes 128, odd lanes 0
	localparam logic [HIST_W-1:0] HIST_RST_EVEN = 18'd128;
	localparam logic [HIST_W-1:0] HIST_RST_ODD  = 18'd0;

	typedef logic [PIX_W-1:0]                pix_t;
	typedef logic [GAIN_W-1:0]               gain_t;
	typedef logic signed [HIST_W-1:0]        hist_t;
	typedef logic [LANES-1:0][HIST_W-1:0]    row_t;

	function automatic row_t reset_row();
		row_t r;
		for (int i = 0; i < LANES; i++) begin
			r[i] = (i % 2 == 0) ? HIST_RST_EVEN : HIST_RST_ODD;
		end
		return r;
	endfunction

endpackage

>>> rtl/recursive_frame_blend.sv
// Top level of the recursive frame blend: config, pipeline and history forwarding.
//
// Usage:
//   Pixel words enter on pix_valid/pix_ready with lane0..lane3 and frame_start;
//   frame_start marks the first word of a frame and sends the word address to 0.
//   Blended words leave on blend_valid/blend_ready as out0..out3.
//   Registers are written through cfg_we/cfg_index/cfg_data while no word is
//   in flight: 0 mode (0 RGBA, 1 YUV 4:2:2), 1 input gain, 2 history gain,
//   3 frame length in words.
// Timing:
//   The accepting edge reads the history row into the read stage; the edge on
//   which that stage advances registers the blend. One word per clock is
//   sustained while blend_ready is high; the history memory has one read and one
//   write port and a row written in the same cycle as it is read is forwarded.
// Reset:
//   Registers take their reset values and the address returns to 0. History
//   rows read as reset values (even lanes 128, odd lanes 0) until written; a
//   fill mark tracks written rows, so no clearing pass is needed.
// Stall:
//   While blend_ready is low the output word holds; one further word is taken
//   into the read stage, after which pix_ready drops.
`include "recursive_frame_blend_assert.svh"

module recursive_frame_blend #(
	parameter int MAX_FRAME_WORDS = rfb_pkg::MAX_FRAME_WORDS_DEF,
	parameter int ALPHA_LANE      = rfb_pkg::ALPHA_LANE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rfb_pkg::IDX_W-1:0] cfg_index,
	input  logic [rfb_pkg::CFG_W-1:0] cfg_data,
	input  logic                      pix_valid,
	output logic                      pix_ready,
	input  rfb_pkg::pix_t             lane0,
	input  rfb_pkg::pix_t             lane1,
	input  rfb_pkg::pix_t             lane2,
	input  rfb_pkg::pix_t             lane3,
	input  logic                      frame_start,
	output logic                      blend_valid,
	input  logic                      blend_ready,
	output rfb_pkg::pix_t             out0,
	output rfb_pkg::pix_t             out1,
	output rfb_pkg::pix_t             out2,
	output rfb_pkg::pix_t             out3
);

	localparam int AW = (MAX_FRAME_WORDS > 1) ? $clog2(MAX_FRAME_WORDS) : 1;
	localparam int LW = $clog2(MAX_FRAME_WORDS + 1);
	localparam int L  = rfb_pkg::LANES;

	// configuration registers
	logic                     mode_q;
	rfb_pkg::gain_t           input_gain_q;
	rfb_pkg::gain_t           history_gain_q;
	logic [rfb_pkg::FW_W-1:0] frame_words_q;

	// read stage
	logic          s1_valid_q;
	rfb_pkg::pix_t lane_s1 [L];
	logic [AW-1:0] addr_s1;
	logic          fwd_s1;
	rfb_pkg::row_t fwd_row_s1;

	// output stage
	logic          out_valid_q;
	rfb_pkg::pix_t out_q [L];

	logic          accept;
	logic          s1_adv;
	logic [AW-1:0] rd_addr;
	rfb_pkg::row_t rd_row;
	logic          rd_hit;
	rfb_pkg::row_t hist_row;
	rfb_pkg::row_t new_row;
	rfb_pkg::pix_t pix_in [L];
	rfb_pkg::pix_t res [L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= rfb_pkg::MODE_RGBA;
			input_gain_q   <= rfb_pkg::INPUT_GAIN_RST;
			history_gain_q <= rfb_pkg::HISTORY_GAIN_RST;
			frame_words_q  <= rfb_pkg::FRAME_WORDS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rfb_pkg::REG_MODE:         mode_q         <= cfg_data[0];
				rfb_pkg::REG_INPUT_GAIN:   input_gain_q   <= cfg_data[rfb_pkg::GAIN_W-1:0];
				rfb_pkg::REG_HISTORY_GAIN: history_gain_q <= cfg_data[rfb_pkg::GAIN_W-1:0];
				rfb_pkg::REG_FRAME_WORDS:  frame_words_q  <= cfg_data[rfb_pkg::FW_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the read stage when the output register is free or being emptied
	assign s1_adv    = s1_valid_q && (!out_valid_q || blend_ready);
	assign pix_ready = !s1_valid_q || s1_adv;
	assign accept    = pix_valid && pix_ready;

	assign pix_in[0] = lane0;
	assign pix_in[1] = lane1;
	assign pix_in[2] = lane2;
	assign pix_in[3] = lane3;

	rfb_addr #(
		.MAX_FRAME_WORDS(MAX_FRAME_WORDS),
		.AW(AW),
		.LW(LW)
	) u_addr (
		.clk(clk),
		.arst_n(arst_n),
		.frame_words(frame_words_q),
		.frame_start(frame_start),
		.step(accept),
		.cur_addr(rd_addr)
	);

	rfb_hist_mem #(
		.DEPTH(MAX_FRAME_WORDS),
		.AW(AW),
		.LW(LW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr(rd_addr),
		.rd_row(rd_row),
		.rd_hit(rd_hit),
		.we(s1_adv),
		.wr_addr(addr_s1),
		.wr_row(new_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// The memory returns the old row when the word ahead writes the same
	// address on the read edge; keep the row being written and use it instead.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < L; i++) begin
				lane_s1[i] <= pix_in[i];
			end
			addr_s1    <= rd_addr;
			fwd_s1     <= s1_adv && (addr_s1 == rd_addr);
			fwd_row_s1 <= new_row;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			hist_row = fwd_row_s1;
		end else if (rd_hit) begin
			hist_row = rd_row;
		end else begin
			hist_row = rfb_pkg::reset_row();
		end
	end

	for (genvar g = 0; g < L; g++) begin : g_lane
		rfb_blend #(
			.LANE(g),
			.ALPHA_LANE(ALPHA_LANE)
		) u_blend (
			.mode(mode_q),
			.input_gain(input_gain_q),
			.history_gain(history_gain_q),
			.pix(lane_s1[g]),
			.hist(hist_row[g]),
			.res(res[g]),
			.hist_new(new_row[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (blend_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int i = 0; i < L; i++) begin
				out_q[i] <= res[i];
			end
		end
	end

	assign blend_valid = out_valid_q;
	assign out0 = out_q[0];
	assign out1 = out_q[1];
	assign out2 = out_q[2];
	assign out3 = out_q[3];

	`RFB_ASSERT_NEXT(a_fwd_set, clk, arst_n, accept && s1_adv && addr_s1 == rd_addr, fwd_s1)
	`RFB_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_valid_q && !s1_adv, s1_valid_q && $stable(addr_s1))
	`RFB_ASSERT_NEXT(a_out_load, clk, arst_n, s1_adv, blend_valid)

endmodule

>>> rtl/rfb_addr.sv
// Word address generator: frame start, frame length wrap and advance per word.
module rfb_addr #(
	parameter int MAX_FRAME_WORDS = rfb_pkg::MAX_FRAME_WORDS_DEF,
	parameter int AW = 17,
	parameter int LW = 18
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [rfb_pkg::FW_W-1:0] frame_words,
	input  logic                     frame_start,
	input  logic                     step,
	output logic [AW-1:0]            cur_addr
);

	localparam int CW = (LW > rfb_pkg::FW_W) ? LW : rfb_pkg::FW_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAME_WORDS);

	logic [AW-1:0] addr_q;
	logic [CW-1:0] fw_c;
	logic [CW-1:0] len;
	logic [AW-1:0] base;
	logic [CW-1:0] nxt;

	always_comb begin
		fw_c = CW'(frame_words);
		len  = (fw_c > MAX_C) ? MAX_C : fw_c;
		if (len == '0) begin
			len = CW'(1);
		end
		base = frame_start ? '0 : addr_q;
		// drop an address left beyond a shortened frame
		cur_addr = (CW'(base) >= len) ? '0 : base;
		nxt      = CW'(cur_addr) + CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (step) begin
			addr_q <= (nxt >= len) ? '0 : nxt[AW-1:0];
		end
	end

endmodule

>>> rtl/rfb_hist_mem.sv
// History memory: one row of four lanes per word address, with a fill mark.
`include "recursive_frame_blend_assert.svh"

module rfb_hist_mem #(
	parameter int DEPTH = rfb_pkg::MAX_FRAME_WORDS_DEF,
	parameter int AW = 17,
	parameter int LW = 18
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output rfb_pkg::row_t rd_row,
	output logic          rd_hit,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  rfb_pkg::row_t wr_row
);

	rfb_pkg::row_t mem [DEPTH];
	logic [LW-1:0] fill_q;
	logic          rd_hit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row <= mem[rd_addr];
		end
	end

	// Rows are written in address order from zero, so every row below the
	// fill mark holds written data and the rest still read as reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (we && LW'(wr_addr) == fill_q) begin
				fill_q <= fill_q + LW'(1);
			end
			if (rd_en) begin
				rd_hit_q <= LW'(rd_addr) < fill_q;
			end
		end
	end

	assign rd_hit = rd_hit_q;

	`RFB_ASSERT_NOW(a_write_in_prefix, clk, arst_n, we, LW'(wr_addr) <= fill_q)
	`RFB_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q <= LW'(DEPTH))

endmodule

>>> rtl/rfb_blend.sv
// One lane of the blend: clamp history, weight, sum and saturate; the alpha lane passes through in RGBA mode.
module rfb_blend #(
	parameter int LANE = 0,
	parameter int ALPHA_LANE = rfb_pkg::ALPHA_LANE_DEF
) (
	input  logic           mode,
	input  rfb_pkg::gain_t input_gain,
	input  rfb_pkg::gain_t history_gain,
	input  rfb_pkg::pix_t  pix,
	input  rfb_pkg::hist_t hist,
	output rfb_pkg::pix_t  res,
	output rfb_pkg::hist_t hist_new
);

	localparam bit IS_ALPHA  = (LANE == ALPHA_LANE);
	localparam bit IS_CHROMA = (LANE % 2 == 0);

	logic [7:0]         hc8;
	logic [15:0]        px;
	logic [15:0]        ph8;
	logic [16:0]        rsum;
	logic [7:0]         rres;
	logic [15:0]        hc16;
	logic [23:0]        ph16;
	logic [16:0]        ysum;
	logic [15:0]        ysat;
	logic signed [15:0] hcs;
	logic signed [8:0]  xc;
	logic signed [16:0] cp;
	logic signed [16:0] hp;
	logic signed [17:0] csum;
	logic signed [15:0] csat;

	always_comb begin
		// RGBA colour lane
		hc8  = hist[17] ? 8'd0 : ((hist > 18'sd255) ? 8'd255 : hist[7:0]);
		px   = pix * input_gain;
		ph8  = hc8 * history_gain;
		rsum = {1'b0, px} + {1'b0, ph8};
		rres = rsum[16] ? 8'd255 : rsum[15:8];

		// luma: history carries eight fraction bits
		hc16 = hist[17] ? 16'd0 : ((hist > 18'sd65535) ? 16'hFFFF : hist[15:0]);
		ph16 = hc16 * history_gain;
		ysum = {1'b0, px} + {1'b0, ph16[23:8]};
		ysat = ysum[16] ? 16'hFFFF : ysum[15:0];

		// chroma: blend around the offset of 128
		if (hist < -18'sd32768) begin
			hcs = -16'sd32768;
		end else if (hist > 18'sd32767) begin
			hcs = 16'sd32767;
		end else begin
			hcs = hist[15:0];
		end
		xc   = $signed({1'b0, pix}) - 9'sd128;
		cp   = xc * $signed({1'b0, input_gain});
		hp   = $signed(hcs[15:8]) * $signed({1'b0, history_gain});
		csum = 18'(cp) + 18'(hp);
		if (csum < -18'sd32768) begin
			csat = -16'sd32768;
		end else if (csum > 18'sd32767) begin
			csat = 16'sd32767;
		end else begin
			csat = csum[15:0];
		end

		if (mode == rfb_pkg::MODE_RGBA) begin
			if (IS_ALPHA) begin
				// pass through, keep history as it was
				res      = pix;
				hist_new = hist;
			end else begin
				res      = rres;
				hist_new = {10'd0, rres};
			end
		end else if (IS_CHROMA) begin
			res      = {~csat[15], csat[14:8]};
			hist_new = {{2{csat[15]}}, csat};
		end else begin
			res      = ysat[15:8];
			hist_new = {2'd0, ysat};
		end
	end

endmodule
